// ===== hdl/mssu_pkg.sv =====
// ----------------------------------------------------------------------------
// mssu_pkg
// Shared types, codes and the hex font of the seven-segment scanner.
// ----------------------------------------------------------------------------
package mssu_pkg;

   // Field widths of the channels.
   localparam int ModeWidth     = 1;
   localparam int IndexWidth    = 4;
   localparam int CodeWidth     = 8;
   localparam int PatternWidth  = 8;
   localparam int SelectWidth   = 11;
   localparam int DispModeWidth = 2;

   // Item kinds on the request channel.
   localparam logic [ModeWidth-1:0] MODE_TICK  = 1'b0;
   localparam logic [ModeWidth-1:0] MODE_WRITE = 1'b1;

   // Display mode register values; the unused code shows blank.
   localparam logic [DispModeWidth-1:0] DISP_NORMAL = 2'd0;
   localparam logic [DispModeWidth-1:0] DISP_BLANK  = 2'd1;
   localparam logic [DispModeWidth-1:0] DISP_DASH   = 2'd2;

   // Code layout and pattern constants.
   localparam logic [CodeWidth-1:0]    GLYPH_MASK     = 8'h0F;
   localparam logic [CodeWidth-1:0]    POINT_REQ_MASK = 8'hF0;
   localparam logic [PatternWidth-1:0] POINT_BIT      = 8'h80;
   localparam logic [3:0]              GLYPH_LIMIT    = 4'd10;
   localparam logic [PatternWidth-1:0] BLANK_PATTERN  = 8'h00;
   localparam logic [PatternWidth-1:0] DASH_PATTERN   = 8'h40;

   typedef logic [ModeWidth-1:0]     mode_type;
   typedef logic [IndexWidth-1:0]    index_type;
   typedef logic [CodeWidth-1:0]     code_type;
   typedef logic [PatternWidth-1:0]  pattern_type;
   typedef logic [SelectWidth-1:0]   select_type;
   typedef logic [DispModeWidth-1:0] disp_mode_type;

   // One result beat.
   typedef struct packed {
      pattern_type segment_pattern;
      select_type  digit_select;
   } rsp_data_type;

   // Occupancy of the output buffer, seen by the top level.
   typedef struct packed {
      logic head_valid;
      logic skid_valid;
      logic pop;
   } buf_status_type;

   // Hex font, segments a..g on bits 0..6.
   function automatic pattern_type hex_font(input logic [3:0] glyph);
      pattern_type pat;
      unique case (glyph)
         4'h0: pat = 8'h3F;
         4'h1: pat = 8'h06;
         4'h2: pat = 8'h5B;
         4'h3: pat = 8'h4F;
         4'h4: pat = 8'h66;
         4'h5: pat = 8'h6D;
         4'h6: pat = 8'h7D;
         4'h7: pat = 8'h27;
         4'h8: pat = 8'h7F;
         4'h9: pat = 8'h6F;
         4'hA: pat = 8'h77;
         4'hB: pat = 8'h7C;
         4'hC: pat = 8'h39;
         4'hD: pat = 8'h5E;
         4'hE: pat = 8'h79;
         default: pat = 8'h71;
      endcase
      return pat;
   endfunction

endpackage

// ===== hdl/mssu_ifs.sv =====
// ----------------------------------------------------------------------------
// mssu channel interfaces
// Request, result and control-register channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel: scan ticks and digit writes.
interface mssu_req_if import mssu_pkg::*;;
   logic      valid;
   logic      ready;
   mode_type  mode;
   index_type digit_index;
   code_type  digit_code;

   modport source (output valid, output mode, output digit_index, output digit_code,
                   input ready);
   modport sink (input valid, input mode, input digit_index, input digit_code,
                 output ready);
endinterface

// Result channel: one pattern and digit select per beat.
interface mssu_rsp_if import mssu_pkg::*;;
   logic        valid;
   logic        ready;
   pattern_type segment_pattern;
   select_type  digit_select;

   modport source (output valid, output segment_pattern, output digit_select,
                   input ready);
   modport sink (input valid, input segment_pattern, input digit_select,
                 output ready);
endinterface

// Control register write channel: display mode.
interface mssu_csr_if import mssu_pkg::*;;
   logic          valid;
   logic          ready;
   disp_mode_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/mssu_ram.sv =====
// ----------------------------------------------------------------------------
// mssu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mssu_ram #(
   parameter int Width     = 8,
   parameter int Depth     = 16,
   parameter int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mssu_out_buf.sv =====
// ----------------------------------------------------------------------------
// mssu_out_buf
// Two-entry output buffer: a head register that drives the result channel
// and a skid register that catches a beat while the head is stalled.
// ----------------------------------------------------------------------------
module mssu_out_buf import mssu_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  rsp_data_type   push_data,
   mssu_rsp_if.source     rsp_bus,
   output buf_status_type status
);

   logic         head_valid_ff, head_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_data_type head_data_ff, head_data_in;
   rsp_data_type skid_data_ff, skid_data_in;
   logic         pop;

   assign pop = head_valid_ff & rsp_bus.ready;

   // Next-state of head and skid entries.
   always_comb begin
      head_valid_in = head_valid_ff;
      head_data_in  = head_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (pop) begin
            head_valid_in = 1'b1;
            head_data_in  = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end
      end else if (!head_valid_ff || pop) begin
         head_valid_in = push;
         head_data_in  = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   // Control bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      head_data_ff <= head_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_bus.valid           = head_valid_ff;
   assign rsp_bus.segment_pattern = head_data_ff.segment_pattern;
   assign rsp_bus.digit_select    = head_data_ff.digit_select;

   assign status.head_valid = head_valid_ff;
   assign status.skid_valid = skid_valid_ff;
   assign status.pop        = pop;

endmodule

// ===== hdl/multiplexed_seven_segment_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scanner_unit
// Holds one code byte per display digit in a RAM and scans the digits:
// each tick beat decodes the digit under the scan pointer into a segment
// pattern with a one-hot digit select, then advances the pointer.
//
//   Channel   Dir   Beat contents
//   req_bus   in    mode, digit_index, digit_code
//   rsp_bus   out   segment_pattern, digit_select
//   csr_bus   in    display mode (2 bits), always ready
//
// One request beat per cycle while the buffer has room. A tick reads the
// digit RAM at accept; its result is registered in the read stage, then in
// the output head register. Writes go straight into the RAM. Requests stall
// while buffered beats and an in-flight tick would fill both output buffer
// entries. Reset is synchronous; the digit store reads as zero per entry
// until written, tracked by one valid bit per digit, with no clearing pass.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_scanner_unit import mssu_pkg::*; #(
   parameter int DIGIT_COUNT = 11
) (
   input logic        clock,
   input logic        reset,
   mssu_req_if.sink   req_bus,
   mssu_rsp_if.source rsp_bus,
   mssu_csr_if.sink   csr_bus
);

   localparam int AddrWidth = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam logic [AddrWidth-1:0] LastDigit = AddrWidth'(DIGIT_COUNT - 1);

   logic                   req_accept;
   logic                   tick_accept;
   logic                   write_accept;
   logic                   index_in_range;
   logic [AddrWidth-1:0]   wr_addr;
   code_type               rd_data;

   disp_mode_type          disp_mode_ff;
   logic [AddrWidth-1:0]   scan_ptr_ff, scan_ptr_in;
   logic [DIGIT_COUNT-1:0] entry_valid_ff;
   logic                   s1_valid_ff;
   logic                   s1_entry_valid_ff;
   logic [AddrWidth-1:0]   s1_ptr_ff;

   code_type               cur_code;
   logic [3:0]             glyph;
   pattern_type            font_pat;
   logic                   push;
   rsp_data_type           push_data;
   buf_status_type         buf_status;
   logic [1:0]             occupancy;

   // Request handshake: accept while the in-flight tick and buffered beats
   // leave room in the output buffer.
   assign occupancy = 2'(buf_status.head_valid) + 2'(buf_status.skid_valid)
                    + 2'(s1_valid_ff) - 2'(buf_status.pop);
   assign req_bus.ready = (occupancy <= 2'd1);
   assign req_accept    = req_bus.valid & req_bus.ready;
   assign tick_accept   = req_accept & (req_bus.mode == MODE_TICK);
   assign write_accept  = req_accept & (req_bus.mode == MODE_WRITE);

   assign index_in_range = ({1'b0, req_bus.digit_index} < (IndexWidth + 1)'(DIGIT_COUNT));
   assign wr_addr        = req_bus.digit_index[AddrWidth-1:0];

   // Control register.
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_mode_ff <= DISP_DASH;
      end else if (csr_bus.valid) begin
         disp_mode_ff <= csr_bus.data;
      end
   end

   // Digit store.
   mssu_ram #(
      .Width (CodeWidth),
      .Depth (DIGIT_COUNT)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (write_accept & index_in_range),
      .wr_addr (wr_addr),
      .wr_data (req_bus.digit_code),
      .rd_en   (tick_accept),
      .rd_addr (scan_ptr_ff),
      .rd_data (rd_data)
   );

   // Scan pointer advances with wrap on each tick.
   assign scan_ptr_in = (scan_ptr_ff == LastDigit) ? '0 : scan_ptr_ff + 1'b1;

   // Pointer, per-digit written flags and the read stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ptr_ff    <= '0;
         entry_valid_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= tick_accept;
         if (tick_accept) begin
            scan_ptr_ff <= scan_ptr_in;
         end
         if (write_accept && index_in_range) begin
            entry_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick_accept) begin
         s1_ptr_ff         <= scan_ptr_ff;
         s1_entry_valid_ff <= entry_valid_ff[scan_ptr_ff];
      end
   end

   // Decode the code read from the store.
   assign cur_code = s1_entry_valid_ff ? rd_data : '0;
   assign glyph    = cur_code[3:0] & GLYPH_MASK[3:0];
   assign font_pat = hex_font(glyph)
                   | (((cur_code & POINT_REQ_MASK) != '0) ? POINT_BIT : BLANK_PATTERN);

   always_comb begin
      push_data.digit_select = SelectWidth'(1) << s1_ptr_ff;
      unique case (disp_mode_ff)
         DISP_NORMAL: push_data.segment_pattern = font_pat;
         DISP_DASH:   push_data.segment_pattern = DASH_PATTERN;
         default:     push_data.segment_pattern = BLANK_PATTERN;
      endcase
   end

   // Glyphs above ten give no result.
   assign push = s1_valid_ff & (glyph <= GLYPH_LIMIT);

   mssu_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_bus   (rsp_bus),
      .status    (buf_status)
   );

`ifndef ASSERT_OFF
   // The skid entry is only ever filled behind a full head.
   assert property (@(posedge clock) disable iff (reset)
      buf_status.skid_valid |-> buf_status.head_valid)
      else $error("Skid entry holds a beat while the head is empty.");

   // The scan pointer always names an existing digit.
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, scan_ptr_ff} < (AddrWidth + 1)'(DIGIT_COUNT)))
      else $error("Scan pointer is out of range.");

   // Requests stall only when the output buffer holds a beat.
   assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> buf_status.head_valid)
      else $error("Request side stalled with an empty output buffer.");

   // A buffered beat is held until the sink takes it.
   assert property (@(posedge clock) disable iff (reset)
      (buf_status.head_valid && !buf_status.pop) |=> buf_status.head_valid)
      else $error("Output beat dropped without a handshake.");
`endif

endmodule
